// File: sv/fqs_pkg.sv
// fqs_pkg: shared types and constants for the searchable FIFO queue.
// Holds the queue depth, the derived widths, action and status codes and the memory request.
// No dependencies.
`timescale 1ns / 1ps

package fqs_pkg;

  // Queue geometry
  localparam int Depth = 16;
  localparam int IdxW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam int WordW = 32;

  localparam logic [IdxW-1:0] LastIdx  = IdxW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  // Action codes of an input transaction
  typedef enum logic [2:0] {
    ACT_ENQ      = 3'd0,
    ACT_DEQ      = 3'd1,
    ACT_PEEK_FR  = 3'd2,
    ACT_PEEK_RR  = 3'd3,
    ACT_SEARCH   = 3'd4,
    ACT_REPL_FR  = 3'd5,
    ACT_REPL_RR  = 3'd6,
    ACT_CLEAR    = 3'd7
  } action_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // One access to the entry store
  typedef struct packed {
    logic             we;
    logic [IdxW-1:0]  waddr;
    logic [WordW-1:0] wdata;
    logic             re;
    logic [IdxW-1:0]  raddr;
  } mem_req_t;

  // Circular increment of a slot index
  function automatic logic [IdxW-1:0] wrap_inc(input logic [IdxW-1:0] idx);
    logic [IdxW-1:0] nxt;
    nxt = (idx == LastIdx) ? '0 : idx + IdxW'(1);
    return nxt;
  endfunction

  // Circular decrement of a slot index
  function automatic logic [IdxW-1:0] wrap_dec(input logic [IdxW-1:0] idx);
    logic [IdxW-1:0] prv;
    prv = (idx == '0) ? LastIdx : idx - IdxW'(1);
    return prv;
  endfunction

endpackage

// File: sv/fqs_mem.sv
// fqs_mem: entry store of the queue, one write and one registered read port.
// Depends on fqs_pkg for depth, widths and the request struct.
`timescale 1ns / 1ps

module fqs_mem (
  input  logic                     clk_i,
  input  fqs_pkg::mem_req_t        req_i,
  output logic [fqs_pkg::WordW-1:0] rdata_o
);

  logic [fqs_pkg::WordW-1:0] mem_q [fqs_pkg::Depth];
  logic [fqs_pkg::WordW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/fqs_ctrl.sv
// fqs_ctrl: sequencer of the queue with indices, count, the shared compare unit
// and the output register. Depends on fqs_pkg; drives fqs_mem through a request struct.
`timescale 1ns / 1ps

module fqs_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [2:0]                       action_i,
  input  logic signed [fqs_pkg::WordW-1:0] value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic signed [fqs_pkg::WordW-1:0] data_out_o,
  output logic [fqs_pkg::CntW-1:0]         position_o,
  output logic [fqs_pkg::CntW-1:0]         count_o,
  output fqs_pkg::mem_req_t                mem_req_o,
  input  logic [fqs_pkg::WordW-1:0]        mem_rdata_i
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_RDWAIT = 6'b000100,
    S_SRD    = 6'b001000,
    S_SCMP   = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [fqs_pkg::IdxW-1:0]  head_q, head_d;
  logic [fqs_pkg::IdxW-1:0]  tail_q, tail_d;
  logic [fqs_pkg::CntW-1:0]  count_q, count_d;
  logic [fqs_pkg::IdxW-1:0]  scan_slot_q, scan_slot_d;
  logic [fqs_pkg::IdxW-1:0]  scan_i_q, scan_i_d;

  // Latched transaction
  fqs_pkg::action_e          act_q;
  logic [fqs_pkg::WordW-1:0] val_q;

  // Pending result
  fqs_pkg::status_e          res_status_q, res_status_d;
  logic [fqs_pkg::WordW-1:0] res_data_q, res_data_d;
  logic [fqs_pkg::CntW-1:0]  res_pos_q, res_pos_d;

  // Output register
  logic                      out_valid_q, out_valid_d;
  logic [1:0]                out_status_q;
  logic [fqs_pkg::WordW-1:0] out_data_q;
  logic [fqs_pkg::CntW-1:0]  out_pos_q;
  logic [fqs_pkg::CntW-1:0]  out_count_q;

  logic in_acc;
  logic out_load;
  logic is_empty;
  logic hit;
  logic last_scan;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign is_empty   = (count_q == '0);

  // Shared compare unit: stored word against the search key
  assign hit       = (mem_rdata_i == val_q);
  assign last_scan = ((fqs_pkg::CntW'(scan_i_q) + fqs_pkg::CntW'(1)) == count_q);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    scan_slot_d  = scan_slot_q;
    scan_i_d     = scan_i_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    res_pos_d    = res_pos_q;
    mem_req_o    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_status_d = fqs_pkg::ST_OK;
        res_data_d   = '0;
        res_pos_d    = '0;
        state_d      = S_DONE;
        unique case (act_q)
          fqs_pkg::ACT_ENQ: begin
            if (count_q >= fqs_pkg::DepthCnt) begin
              res_status_d = fqs_pkg::ST_FULL;
            end else begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = tail_q;
              mem_req_o.wdata = val_q;
              tail_d          = fqs_pkg::wrap_inc(tail_q);
              count_d         = count_q + fqs_pkg::CntW'(1);
            end
          end
          fqs_pkg::ACT_DEQ,
          fqs_pkg::ACT_PEEK_FR: begin
            if (is_empty) begin
              res_status_d = fqs_pkg::ST_EMPTY;
              res_data_d   = '1;
            end else begin
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = head_q;
              state_d         = S_RDWAIT;
              if (act_q == fqs_pkg::ACT_DEQ) begin
                head_d  = fqs_pkg::wrap_inc(head_q);
                count_d = count_q - fqs_pkg::CntW'(1);
              end
            end
          end
          fqs_pkg::ACT_PEEK_RR: begin
            if (is_empty) begin
              res_status_d = fqs_pkg::ST_EMPTY;
              res_data_d   = '1;
            end else begin
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = fqs_pkg::wrap_dec(tail_q);
              state_d         = S_RDWAIT;
            end
          end
          fqs_pkg::ACT_SEARCH: begin
            if (!is_empty) begin
              scan_slot_d = head_q;
              scan_i_d    = '0;
              state_d     = S_SRD;
            end
          end
          fqs_pkg::ACT_REPL_FR,
          fqs_pkg::ACT_REPL_RR: begin
            if (is_empty) begin
              res_status_d = fqs_pkg::ST_EMPTY;
              res_data_d   = '1;
            end else begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = (act_q == fqs_pkg::ACT_REPL_FR) ? head_q
                                                                : fqs_pkg::wrap_dec(tail_q);
              mem_req_o.wdata = val_q;
            end
          end
          fqs_pkg::ACT_CLEAR: begin
            head_d  = '0;
            tail_d  = '0;
            count_d = '0;
          end
          default: ;
        endcase
      end

      // Read data of a dequeue or peek is back
      S_RDWAIT: begin
        res_data_d = mem_rdata_i;
        state_d    = S_DONE;
      end

      // Search: fetch the next entry from the front
      S_SRD: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = scan_slot_q;
        state_d         = S_SCMP;
      end

      // Search: compare it, stop on a match or after the rear entry
      S_SCMP: begin
        if (hit) begin
          res_pos_d = fqs_pkg::CntW'(scan_i_q) + fqs_pkg::CntW'(1);
          state_d   = S_DONE;
        end else if (last_scan) begin
          state_d = S_DONE;
        end else begin
          scan_i_d    = scan_i_q + fqs_pkg::IdxW'(1);
          scan_slot_d = fqs_pkg::wrap_inc(scan_slot_q);
          state_d     = S_SRD;
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    scan_slot_q  <= scan_slot_d;
    scan_i_q     <= scan_i_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    res_pos_q    <= res_pos_d;
    if (in_acc) begin
      act_q <= fqs_pkg::action_e'(action_i);
      val_q <= value_i;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_data_q   <= res_data_q;
      out_pos_q    <= res_pos_q;
      out_count_q  <= count_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign data_out_o  = out_data_q;
  assign position_o  = out_pos_q;
  assign count_o     = out_count_q;

`ifndef SYNTH
  // Count stays within the queue depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= fqs_pkg::DepthCnt)
    else $error("entry count above depth");

  // An accepted transaction is executed in the next cycle
  a_acc_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_EXEC))
    else $error("accepted transaction not executed");

  // A new result only comes from the done state
  a_load_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result loaded outside done state");

  // A search hit never lies beyond the stored entries
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_pos_q <= out_count_q))
    else $error("search position beyond count");
`endif

endmodule

// File: sv/fifo_queue_with_search_top.sv
// fifo_queue_with_search_top: top level of the searchable FIFO queue.
// Depends on fqs_pkg, fqs_mem and fqs_ctrl.
`timescale 1ns / 1ps

// A 16-entry FIFO of 32-bit signed words that takes one action per transaction:
// enqueue, dequeue, peek front or rear, search, replace front or rear, or clear,
// and returns exactly one result with status, word, search position and count.
// The block works on one transaction at a time and stalls its input meanwhile;
// a finished result sits in an output register so the next transaction can be
// taken while it waits. A dequeue or peek waits for the registered read data of
// the single read port of the entry store; a search steps from the front, and
// each step reads one entry and then compares it in the shared compare unit.
// The store needs no clearing after reset.

module fifo_queue_with_search_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [2:0]                       action_i,
  input  logic signed [fqs_pkg::WordW-1:0] value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic signed [fqs_pkg::WordW-1:0] data_out_o,
  output logic [fqs_pkg::CntW-1:0]         position_o,
  output logic [fqs_pkg::CntW-1:0]         count_o
);

  fqs_pkg::mem_req_t         mem_req;
  logic [fqs_pkg::WordW-1:0] mem_rdata;

  fqs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .data_out_o  (data_out_o),
    .position_o  (position_o),
    .count_o     (count_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  fqs_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

// File: test/fqs_queue_checker.sv
// fqs_queue_checker: watches both channels of the searchable FIFO queue and checks each result.
// It keeps its own copy of the queue, predicts one result per input transaction and compares fields.
// Depends on fqs_pkg.
`timescale 1ns / 1ps

module fqs_queue_checker
  import fqs_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [2:0]              action_i,
  input  logic signed [WordW-1:0] value_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [1:0]              status_i,
  input  logic signed [WordW-1:0] data_out_i,
  input  logic [CntW-1:0]         position_i,
  input  logic [CntW-1:0]         count_i,
  output int                      fail_cnt_o,
  output int                      pending_o,
  output int                      checked_o,
  output int                      full_rejects_o,
  output int                      empty_hits_o,
  output int                      search_hits_o
);

  typedef struct {
    status_e                 status;
    logic signed [WordW-1:0] data;
    logic [CntW-1:0]         pos;
    logic [CntW-1:0]         cnt;
  } queue_result_t;

  // Shadow copy of the queue
  logic signed [WordW-1:0] words_q [Depth];
  logic [IdxW-1:0]         front_q;
  logic [IdxW-1:0]         next_free_q;
  logic [CntW-1:0]         fill_q;

  queue_result_t due_results [$];
  queue_result_t got_due;

  function automatic logic [IdxW-1:0] step_slot(input logic [IdxW-1:0] idx);
    return IdxW'((int'(idx) + 1) % Depth);
  endfunction

  // Works out the result of one action and updates the shadow queue
  task automatic apply_queue_action(input action_e act, input logic signed [WordW-1:0] val);
    queue_result_t   res;
    logic [IdxW-1:0] slot;
    logic [IdxW-1:0] rear;
    res.status = ST_OK;
    res.data   = '0;
    res.pos    = '0;
    rear = IdxW'((int'(next_free_q) + Depth - 1) % Depth);
    case (act)
      ACT_ENQ: begin
        if (fill_q == CntW'(Depth)) begin
          res.status = ST_FULL;
        end else begin
          words_q[next_free_q] = val;
          next_free_q = step_slot(next_free_q);
          fill_q++;
        end
      end
      ACT_DEQ, ACT_PEEK_FR, ACT_PEEK_RR, ACT_REPL_FR, ACT_REPL_RR: begin
        if (fill_q == '0) begin
          res.status = ST_EMPTY;
          res.data   = -1;
        end else begin
          case (act)
            ACT_DEQ: begin
              res.data = words_q[front_q];
              front_q = step_slot(front_q);
              fill_q--;
            end
            ACT_PEEK_FR: res.data = words_q[front_q];
            ACT_PEEK_RR: res.data = words_q[rear];
            ACT_REPL_FR: words_q[front_q] = val;
            default:     words_q[rear] = val;
          endcase
        end
      end
      ACT_SEARCH: begin
        // first match counted from the front, 1-based
        slot = front_q;
        for (int i = 0; i < int'(fill_q); i++) begin
          if (words_q[slot] == val && res.pos == '0) res.pos = CntW'(i + 1);
          slot = step_slot(slot);
        end
      end
      default: begin
        front_q     = '0;
        next_free_q = '0;
        fill_q      = '0;
      end
    endcase
    res.cnt = fill_q;
    if (res.status == ST_FULL) full_rejects_o++;
    if (res.status == ST_EMPTY) empty_hits_o++;
    if (res.pos != '0) search_hits_o++;
    due_results.push_back(res);
  endtask

  task automatic check_field(input string name, input logic signed [WordW-1:0] want,
                             input logic signed [WordW-1:0] got);
    if (got !== want) begin
      fail_cnt_o++;
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
    end
  endtask

  // Results are compared first; a result never belongs to a transaction of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) words_q[i] = '0;
      front_q        = '0;
      next_free_q    = '0;
      fill_q         = '0;
      due_results.delete();
      fail_cnt_o     = 0;
      pending_o      = 0;
      checked_o      = 0;
      full_rejects_o = 0;
      empty_hits_o   = 0;
      search_hits_o  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          fail_cnt_o++;
          $error("result with no transaction pending: status %0d data %0d count %0d",
                 status_i, data_out_i, count_i);
        end else begin
          got_due = due_results.pop_front();
          check_field("status", got_due.status, status_i);
          check_field("data_out", got_due.data, data_out_i);
          check_field("position", got_due.pos, position_i);
          check_field("count", got_due.cnt, count_i);
          checked_o++;
        end
      end
      if (in_valid_i && !in_stall_i) apply_queue_action(action_e'(action_i), value_i);
      pending_o = due_results.size();
    end
  end

endmodule

// File: test/tb_top.sv
// tb_top: stimulus and verdict for the searchable FIFO queue.
// Drives directed corners and biased random transactions; checking sits in fqs_queue_checker.
// Depends on fqs_pkg, fifo_queue_with_search_top and fqs_queue_checker.
`timescale 1ns / 1ps

module tb_top;
  import fqs_pkg::*;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic [2:0]              action;
  logic signed [WordW-1:0] value;
  logic                    out_stall;

  logic                    in_stall;
  logic                    out_valid;
  logic [1:0]              status;
  logic signed [WordW-1:0] data_out;
  logic [CntW-1:0]         position;
  logic [CntW-1:0]         count;

  int fail_cnt, pending, checked, full_rejects, empty_hits, search_hits;
  int items_sent;
  bit calm;       // no idling on either side
  bit hold_req;   // ask the receiver for one long hold-off
  bit hold_done;

  logic signed [WordW-1:0] recent_words [$];

  fifo_queue_with_search_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .action_i    (action),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .status_o    (status),
    .data_out_o  (data_out),
    .position_o  (position),
    .count_o     (count)
  );

  fqs_queue_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .action_i       (action),
    .value_i        (value),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .status_i       (status),
    .data_out_i     (data_out),
    .position_i     (position),
    .count_i        (count),
    .fail_cnt_o     (fail_cnt),
    .pending_o      (pending),
    .checked_o      (checked),
    .full_rejects_o (full_rejects),
    .empty_hits_o   (empty_hits),
    .search_hits_o  (search_hits)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Offer one transaction and hold it until accepted, then maybe drop valid and idle
  task automatic push_item(input action_e act, input logic signed [WordW-1:0] val);
    in_valid <= 1'b1;
    action   <= act;
    value    <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (act == ACT_ENQ || act == ACT_REPL_FR || act == ACT_REPL_RR) begin
      recent_words.push_back(val);
      if (recent_words.size() > 24) void'(recent_words.pop_front());
    end
    if (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  // Enqueue-heavy while filling, dequeue-heavy while draining
  function automatic action_e pick_action(input bit filling);
    int r;
    int enq_w;
    int deq_w;
    r     = $urandom_range(99);
    enq_w = filling ? 50 : 15;
    deq_w = filling ? 10 : 45;
    if (r < 2) return ACT_CLEAR;
    r -= 2;
    if (r < enq_w) return ACT_ENQ;
    r -= enq_w;
    if (r < deq_w) return ACT_DEQ;
    r -= deq_w;
    if (r < 6) return ACT_PEEK_FR;
    if (r < 12) return ACT_PEEK_RR;
    if (r < 26) return ACT_SEARCH;
    if (r < 32) return ACT_REPL_FR;
    return ACT_REPL_RR;
  endfunction

  // Mix of stored words (search hits), extremes, small repeats and full-range words
  function automatic logic signed [WordW-1:0] pick_value();
    int sel;
    sel = $urandom_range(9);
    if (sel < 4 && recent_words.size() > 0)
      return recent_words[$urandom_range(recent_words.size() - 1)];
    case (sel)
      4: begin
        case ($urandom_range(3))
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          2:       return -1;
          default: return 0;
        endcase
      end
      5, 6:    return $urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random stalls, one long hold-off on request
  initial begin
    out_stall = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
        hold_done = 1'b1;
      end
      out_stall <= !calm && ($urandom_range(99) < 23);
    end
  end

  // Stimulus
  initial begin
    action_e                 act;
    logic signed [WordW-1:0] word;
    logic signed [WordW-1:0] last_word;
    bit                      filling;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    action     = ACT_ENQ;
    value      = '0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    items_sent = 0;
    filling    = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty-queue corners: peeks, dequeue and replaces report empty, search finds nothing
    push_item(ACT_PEEK_FR, 32'sd5);
    push_item(ACT_PEEK_RR, -1);
    push_item(ACT_DEQ, 0);
    push_item(ACT_REPL_FR, 32'sh7FFF_FFFF);
    push_item(ACT_REPL_RR, 32'sh8000_0000);
    push_item(ACT_SEARCH, 0);

    // Fill up with the extreme words first, then refuse one more
    last_word = '0;
    for (int i = 0; i < Depth; i++) begin
      case (i)
        0:       word = 32'sh7FFF_FFFF;
        1:       word = 32'sh8000_0000;
        2:       word = -1;
        3:       word = 0;
        default: word = $urandom;
      endcase
      push_item(ACT_ENQ, word);
      last_word = word;
    end
    push_item(ACT_ENQ, 32'sd42);
    push_item(ACT_SEARCH, last_word);
    push_item(ACT_PEEK_FR, 0);
    push_item(ACT_PEEK_RR, 0);
    push_item(ACT_REPL_FR, -1);
    push_item(ACT_REPL_RR, 32'sh8000_0000);
    push_item(ACT_DEQ, 0);
    push_item(ACT_CLEAR, 0);

    // Random part: alternating fill and drain phases push the queue through full and empty
    for (int n = 0; n < 700; n++) begin
      if (n % 40 == 0) filling = !filling;
      if (n == 150) hold_req = 1'b1;
      if (n == 250) calm = 1'b1;
      if (n == 380) calm = 1'b0;
      if (n == 450) drain_results();
      act = pick_action(filling);
      push_item(act, pick_value());
    end

    drain_results();
    repeat (60) @(posedge clk);
    $display("Sent %0d transactions, checked %0d results.", items_sent, checked);
    $display("Full refusals %0d, empty-queue results %0d, search hits %0d.",
             full_rejects, empty_hits, search_hits);
    if (fail_cnt == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: fifo_queue_with_search_top.f
sv/fqs_pkg.sv
sv/fqs_mem.sv
sv/fqs_ctrl.sv
sv/fifo_queue_with_search_top.sv
test/fqs_queue_checker.sv
test/tb_top.sv
